/* hdl/hbrp_pkg.sv */
// Types, constants and helper functions for the HTTP byte-range parser.
package hbrp_pkg;

	localparam int VALUE_WIDTH = 48;
	localparam int OUT_W       = 48;
	localparam int SDATA_W     = 8;
	localparam int MDATA_W     = 160;
	localparam int RQ_DEPTH    = 4;
	localparam int RQ_AW       = 2;
	localparam int RQ_CW       = 3;

	typedef logic [VALUE_WIDTH-1:0] value_t;

	localparam value_t VMAX   = '1;
	localparam value_t CUTOFF = value_t'(VMAX / 10);
	localparam value_t CUTLIM = value_t'(VMAX % 10);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [2:0] PREFIX_LAST = 3'd5;

	typedef enum logic [3:0] {
		PH_PREFIX = 4'd0,
		PH_BEGIN  = 4'd1,
		PH_SDIG   = 4'd2,
		PH_SSP    = 4'd3,
		PH_DASH   = 4'd4,
		PH_EFIRST = 4'd5,
		PH_EDIG   = 4'd6,
		PH_ESP    = 4'd7,
		PH_COMMA  = 4'd8
	} phase_t;

	typedef enum logic [1:0] {
		ST_WHOLE   = 2'd0,
		ST_PARTIAL = 2'd1,
		ST_UNSAT   = 2'd2
	} status_t;

	typedef struct packed {
		logic             kind;
		logic [OUT_W-1:0] offset;
		logic [OUT_W-1:0] length;
		status_t          status;
		logic [7:0]       range_count;
		logic [OUT_W-1:0] total_bytes;
		logic             last;
	} result_t;

	// lower-case "bytes="
	function automatic logic [7:0] prefix_char(input logic [2:0] pos);
		logic [7:0] r;
		unique case (pos)
			3'd0:    r = 8'h62;
			3'd1:    r = 8'h79;
			3'd2:    r = 8'h74;
			3'd3:    r = 8'h65;
			3'd4:    r = 8'h73;
			3'd5:    r = 8'h3D;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic value_t eff_size(input logic [OUT_W-1:0] fs);
		logic [VALUE_WIDTH+OUT_W-1:0] t;
		t = {{VALUE_WIDTH{1'b0}}, fs};
		if (|(t >> VALUE_WIDTH))
			return VMAX;
		return t[VALUE_WIDTH-1:0];
	endfunction

	function automatic logic [OUT_W-1:0] to_out(input value_t v);
		logic [VALUE_WIDTH+OUT_W-1:0] t;
		t = {{OUT_W{1'b0}}, v};
		return t[OUT_W-1:0];
	endfunction

endpackage

/* hdl/http_byte_range_parser.sv */
// HTTP Range header parser: one header byte per beat in, range and status beats out.
//
// Header bytes enter one per beat on s_*; a beat with s_tlast high closes the header (its
// byte is ignored). The parser checks a case-insensitive "bytes=" prefix, parses "S-E",
// "S-" and "-N" specs, clamps them to file_size and sends one m_* beat (tuser 0) per
// non-empty range, then on the closing beat a status beat (tuser 1, tlast 1). A byte is
// taken every cycle while the four-entry result queue holds at most two entries: it is
// registered, processed combinationally and written into the result queue. Output is one
// beat per cycle while m_tready is high; a closing byte that completes a range pushes two.
// file_size may only be written while the parser is idle.
module http_byte_range_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          file_size_wr_en,
	input  logic [hbrp_pkg::OUT_W-1:0]    file_size,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [hbrp_pkg::SDATA_W-1:0]  s_tdata,   // [7:0] ch
	input  logic                          s_tlast,   // at_end
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [47:0] offset, [95:48] length, [97:96] status, [105:98] range_count,
	// [153:106] total_bytes, [159:154] zero
	output logic [hbrp_pkg::MDATA_W-1:0]  m_tdata,
	output logic                          m_tuser,   // kind
	output logic                          m_tlast    // last
);
	import hbrp_pkg::*;

	logic [OUT_W-1:0] file_size_q;
	logic             valid_s1;
	logic [7:0]       ch_s1;
	logic             end_s1;

	phase_t     phase_q, phase_d;
	logic [2:0] pos_q, pos_d;
	value_t     start_q, start_d, end_q, end_d, sum_q;
	logic       suffix_q, suffix_d;
	logic [7:0] cnt_q;
	logic       err_q, stopped_q;

	result_t        rq_q [RQ_DEPTH];
	logic [RQ_AW-1:0] rq_wr_q, rq_rd_q;
	logic [RQ_CW-1:0] rq_cnt_q;

	logic       adv, pop, feed_en;
	logic [7:0] c, lc;
	logic       dig, term;
	logic [3:0] d;
	value_t     fs, s_acc, e_acc;
	logic       s_ok, e_ok;
	value_t     fc_start, fc_end, af_start, af_end, len;
	logic       af_closed, af_open, af_go, nonempty;
	logic [VALUE_WIDTH:0] sum_add;
	logic       stop_f, fail_f, emit_rng;
	logic [7:0] cnt_inc, cnt_n;
	value_t     sum_n;
	logic       err_n;
	logic       rng_push;
	logic [1:0] n_push;
	result_t    rng_res, st_res, w0;

	assign adv      = valid_s1 && (rq_cnt_q <= RQ_CW'(RQ_DEPTH - 2));
	assign s_tready = !valid_s1 || adv;
	assign pop      = m_tvalid && m_tready;
	assign feed_en  = !stopped_q;

	assign c    = end_s1 ? CH_NUL : ch_s1;
	assign dig  = (c >= CH_ZERO) && (c <= CH_NINE);
	assign d    = dig ? c[3:0] : 4'd0;
	assign term = (c == CH_COMMA) || (c == CH_NUL) || (c == CH_CR);
	assign lc   = ((c >= CH_UC_A) && (c <= CH_UC_Z)) ? (c | 8'h20) : c;
	assign fs   = eff_size(file_size_q);

	// times ten plus digit, with overflow check against the value limit
	assign s_ok  = !((start_q > CUTOFF) || ((start_q == CUTOFF) && (value_t'(d) > CUTLIM)));
	assign e_ok  = !((end_q > CUTOFF) || ((end_q == CUTOFF) && (value_t'(d) > CUTLIM)));
	assign s_acc = (start_q << 3) + (start_q << 1) + value_t'(d);
	assign e_acc = (end_q << 3) + (end_q << 1) + value_t'(d);

	// clamp a closed or suffix spec
	assign fc_start = suffix_q ? ((end_q < fs) ? fs - end_q : '0) : start_q;
	assign fc_end   = suffix_q ? fs : ((end_q >= fs) ? fs : end_q + value_t'(1));

	assign af_closed = ((phase_q == PH_EDIG) || (phase_q == PH_ESP)) && term;
	assign af_open   = (phase_q == PH_DASH) && ((c == CH_COMMA) || (c == CH_NUL));
	assign af_go     = af_closed || af_open;
	assign af_start  = af_closed ? fc_start : start_q;
	assign af_end    = af_closed ? fc_end : fs;
	assign nonempty  = af_start < af_end;
	assign len       = af_end - af_start;
	assign sum_add   = {1'b0, sum_q} + {1'b0, len};

	// next state
	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		start_d  = start_q;
		end_d    = end_q;
		suffix_d = suffix_q;
		stop_f   = 1'b0;
		fail_f   = 1'b0;
		emit_rng = 1'b0;
		if (phase_q == PH_COMMA && (c == CH_CR || c == CH_NUL)) begin
			stop_f = 1'b1;
		end else begin
			if (phase_q == PH_COMMA) begin
				phase_d  = PH_BEGIN;
				suffix_d = 1'b0;
			end
			unique case ((phase_q == PH_COMMA) ? PH_BEGIN : phase_q)
				PH_PREFIX: begin
					if (c == CH_NUL || pos_q > PREFIX_LAST || lc != prefix_char(pos_q)) begin
						stop_f = 1'b1;
					end else begin
						pos_d = pos_q + 3'd1;
						if (pos_q == PREFIX_LAST) begin
							phase_d  = PH_BEGIN;
							start_d  = '0;
							end_d    = '0;
							suffix_d = 1'b0;
						end
					end
				end
				PH_BEGIN: begin
					if (c == CH_SPACE) begin
					end else if (c == CH_DASH) begin
						suffix_d = 1'b1;
						phase_d  = PH_EFIRST;
					end else if (dig) begin
						start_d = value_t'(d);
						phase_d = PH_SDIG;
					end else begin
						fail_f = 1'b1;
					end
				end
				PH_SDIG: begin
					if (dig) begin
						if (s_ok) start_d = s_acc;
						else fail_f = 1'b1;
					end else if (c == CH_SPACE) phase_d = PH_SSP;
					else if (c == CH_DASH) phase_d = PH_DASH;
					else fail_f = 1'b1;
				end
				PH_SSP: begin
					if (c == CH_SPACE) begin
					end else if (c == CH_DASH) phase_d = PH_DASH;
					else fail_f = 1'b1;
				end
				PH_DASH: begin
					if (c == CH_SPACE || af_go) begin
					end else if (dig) begin
						end_d   = value_t'(d);
						phase_d = PH_EDIG;
					end else fail_f = 1'b1;
				end
				PH_EFIRST: begin
					if (dig) begin
						end_d   = value_t'(d);
						phase_d = PH_EDIG;
					end else fail_f = 1'b1;
				end
				PH_EDIG: begin
					if (dig) begin
						if (e_ok) end_d = e_acc;
						else fail_f = 1'b1;
					end else if (c == CH_SPACE) phase_d = PH_ESP;
					else if (!af_go) fail_f = 1'b1;
				end
				PH_ESP: begin
					if (c == CH_SPACE || af_go) begin
					end else fail_f = 1'b1;
				end
				default: fail_f = 1'b1;
			endcase
			if (af_go) begin
				if (nonempty && sum_add[VALUE_WIDTH]) begin
					fail_f = 1'b1;
				end else if (!nonempty && af_start == '0) begin
					stop_f = 1'b1;
				end else begin
					emit_rng = nonempty;
					if (c != CH_COMMA) stop_f = 1'b1;
					else phase_d = PH_COMMA;
				end
			end
		end
	end

	assign rng_push = feed_en && emit_rng;
	assign cnt_inc  = (cnt_q == 8'hFF) ? cnt_q : cnt_q + 8'd1;
	assign cnt_n    = rng_push ? cnt_inc : cnt_q;
	assign sum_n    = rng_push ? sum_add[VALUE_WIDTH-1:0] : sum_q;
	assign err_n    = err_q || (feed_en && fail_f);

	// result beats
	always_comb begin
		rng_res             = '0;
		rng_res.offset      = to_out(af_start);
		rng_res.length      = to_out(len);
		rng_res.status      = ST_WHOLE;
		rng_res.range_count = cnt_n;
		rng_res.total_bytes = to_out(sum_n);
		st_res              = '0;
		st_res.kind         = 1'b1;
		st_res.last         = 1'b1;
		st_res.range_count  = cnt_n;
		st_res.total_bytes  = to_out(sum_n);
		if (err_n) begin
			st_res.status = ST_UNSAT;
		end else if (cnt_n != 8'd0) begin
			st_res.status = ST_PARTIAL;
		end else begin
			st_res.status      = ST_WHOLE;
			st_res.length      = to_out(fs);
			st_res.total_bytes = to_out(fs);
		end
		w0     = rng_push ? rng_res : st_res;
		n_push = adv ? ({1'b0, rng_push} + {1'b0, end_s1}) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_size_q <= '0;
		end else if (file_size_wr_en) begin
			file_size_q <= file_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ch_s1  <= s_tdata;
			end_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_PREFIX;
			pos_q     <= '0;
			start_q   <= '0;
			end_q     <= '0;
			suffix_q  <= 1'b0;
			sum_q     <= '0;
			cnt_q     <= '0;
			err_q     <= 1'b0;
			stopped_q <= 1'b0;
		end else if (adv) begin
			if (end_s1) begin
				phase_q   <= PH_PREFIX;
				pos_q     <= '0;
				start_q   <= '0;
				end_q     <= '0;
				suffix_q  <= 1'b0;
				sum_q     <= '0;
				cnt_q     <= '0;
				err_q     <= 1'b0;
				stopped_q <= 1'b0;
			end else if (feed_en) begin
				phase_q   <= phase_d;
				pos_q     <= pos_d;
				start_q   <= start_d;
				end_q     <= end_d;
				suffix_q  <= suffix_d;
				sum_q     <= sum_n;
				cnt_q     <= cnt_n;
				err_q     <= err_n;
				stopped_q <= stop_f || fail_f;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q  <= '0;
			rq_rd_q  <= '0;
			rq_cnt_q <= '0;
		end else begin
			rq_wr_q  <= rq_wr_q + RQ_AW'(n_push);
			rq_rd_q  <= rq_rd_q + RQ_AW'(pop);
			rq_cnt_q <= rq_cnt_q + RQ_CW'(n_push) - RQ_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) rq_q[rq_wr_q] <= w0;
		if (n_push == 2'd2) rq_q[rq_wr_q + RQ_AW'(1)] <= st_res;
	end

	assign m_tvalid = rq_cnt_q != '0;
	assign m_tuser  = rq_q[rq_rd_q].kind;
	assign m_tlast  = rq_q[rq_rd_q].last;
	assign m_tdata  = {6'b0, rq_q[rq_rd_q].total_bytes, rq_q[rq_rd_q].range_count,
		rq_q[rq_rd_q].status, rq_q[rq_rd_q].length, rq_q[rq_rd_q].offset};

	a_rq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rq_cnt_q <= RQ_CW'(RQ_DEPTH))
		else $error("result queue overflow");

	a_end_status: assert property (@(posedge clk) disable iff (!arst_n)
		adv && end_s1 |-> n_push != 2'd0)
		else $error("terminator beat without status result");

	a_no_prefix_range: assert property (@(posedge clk) disable iff (!arst_n)
		adv && phase_q == PH_PREFIX |-> !rng_push)
		else $error("range emitted during prefix match");

endmodule

/* test/http_byte_range_parser_checker.sv */
// Scoreboard for the HTTP byte-range parser: tracks the parse, predicts result beats, compares.
module http_byte_range_parser_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         file_size_wr_en,
	input  logic [hbrp_pkg::OUT_W-1:0]   file_size,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [hbrp_pkg::SDATA_W-1:0] s_tdata,   // [7:0] ch
	input  logic                         s_tlast,   // at_end
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	// [47:0] offset, [95:48] length, [97:96] status, [105:98] range_count,
	// [153:106] total_bytes, [159:154] zero
	input  logic [hbrp_pkg::MDATA_W-1:0] m_tdata,
	input  logic                         m_tuser,   // kind
	input  logic                         m_tlast,   // last
	output int                           mismatches,
	output int                           outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import hbrp_pkg::*;

	localparam logic [63:0] VLIMIT      = 64'h0000_FFFF_FFFF_FFFF;
	localparam logic [47:0] PREFIX_TEXT = "bytes=";

	// value width is 48, so the effective size is the register itself
	logic [63:0] fsize;
	phase_t      phase;
	logic [2:0]  pfx_pos;
	logic [63:0] rng_first;
	logic [63:0] rng_end;
	logic        suffix_spec;
	logic [63:0] byte_total;
	logic [7:0]  range_cnt;
	logic        spec_error;
	logic        halted;
	result_t     due_beats[$];
	result_t     want;
	int          err_count = 0;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] wanted);
		if (err_count < 40)
			$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, wanted);
		err_count++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] wanted);
		if (got !== wanted)
			report_mismatch({"field ", name}, got, wanted);
	endtask

	task automatic expect_beat(input logic kind, input logic [63:0] off, input logic [63:0] len,
			input status_t st, input logic [63:0] tot);
		result_t r;
		r.kind        = kind;
		r.offset      = off[OUT_W-1:0];
		r.length      = len[OUT_W-1:0];
		r.status      = st;
		r.range_count = range_cnt;
		r.total_bytes = tot[OUT_W-1:0];
		r.last        = kind;
		due_beats.insert(due_beats.size(), r);
	endtask

	task automatic clear_header();
		phase       = PH_PREFIX;
		pfx_pos     = '0;
		rng_first   = '0;
		rng_end     = '0;
		suffix_spec = 1'b0;
		byte_total  = '0;
		range_cnt   = '0;
		spec_error  = 1'b0;
		halted      = 1'b0;
	endtask

	task automatic flag_error();
		spec_error = 1'b1;
		halted     = 1'b1;
	endtask

	function automatic bit digit_fits(input logic [63:0] v, input logic [3:0] d);
		return !(v >= VLIMIT / 10 && (v > VLIMIT / 10 || d > VLIMIT % 10));
	endfunction

	task automatic close_range(input logic [7:0] c);
		logic [63:0] len;
		if (rng_first < rng_end) begin
			len = rng_end - rng_first;
			if (byte_total > VLIMIT - len) begin
				flag_error();
				return;
			end
			byte_total = byte_total + len;
			if (range_cnt != 8'd255)
				range_cnt++;
			expect_beat(1'b0, rng_first, len, ST_WHOLE, byte_total);
		end else if (rng_first == 0) begin
			halted = 1'b1;
			return;
		end
		if (c != CH_COMMA)
			halted = 1'b1;
		else
			phase = PH_COMMA;
	endtask

	task automatic clamp_and_close(input logic [7:0] c);
		if (suffix_spec) begin
			rng_first = rng_end < fsize ? fsize - rng_end : 64'd0;
			rng_end   = fsize;
		end else begin
			rng_end = rng_end >= fsize ? fsize : rng_end + 64'd1;
		end
		close_range(c);
	endtask

	// NUL stands for the end of the header
	task automatic parse_char(input logic [7:0] c);
		logic       is_dig;
		logic [3:0] d;
		logic [7:0] lc;
		logic       ends_spec;
		is_dig    = c >= CH_ZERO && c <= CH_NINE;
		d         = is_dig ? 4'(c - CH_ZERO) : 4'd0;
		ends_spec = c == CH_COMMA || c == CH_NUL || c == CH_CR;
		if (phase == PH_COMMA) begin
			if (c == CH_CR || c == CH_NUL) begin
				halted = 1'b1;
				return;
			end
			rng_first   = '0;
			rng_end     = '0;
			suffix_spec = 1'b0;
			phase       = PH_BEGIN;
		end
		case (phase)
			PH_PREFIX: begin
				lc = (c >= CH_UC_A && c <= CH_UC_Z) ? c + 8'h20 : c;
				if (c == CH_NUL || pfx_pos > 3'd5 || lc != PREFIX_TEXT[8*(5-pfx_pos) +: 8]) begin
					halted = 1'b1;
				end else begin
					pfx_pos++;
					if (pfx_pos == 3'd6) begin
						rng_first   = '0;
						rng_end     = '0;
						suffix_spec = 1'b0;
						phase       = PH_BEGIN;
					end
				end
			end
			PH_BEGIN: begin
				if (c != CH_SPACE) begin
					if (c == CH_DASH) begin
						suffix_spec = 1'b1;
						phase       = PH_EFIRST;
					end else if (is_dig) begin
						rng_first = 64'(d);
						phase     = PH_SDIG;
					end else begin
						flag_error();
					end
				end
			end
			PH_SDIG: begin
				if (is_dig) begin
					if (digit_fits(rng_first, d))
						rng_first = rng_first * 10 + 64'(d);
					else
						flag_error();
				end else if (c == CH_SPACE) begin
					phase = PH_SSP;
				end else if (c == CH_DASH) begin
					phase = PH_DASH;
				end else begin
					flag_error();
				end
			end
			PH_SSP: begin
				if (c != CH_SPACE) begin
					if (c == CH_DASH)
						phase = PH_DASH;
					else
						flag_error();
				end
			end
			PH_DASH: begin
				if (c != CH_SPACE) begin
					if (c == CH_COMMA || c == CH_NUL) begin
						rng_end = fsize;
						close_range(c);
					end else if (is_dig) begin
						rng_end = 64'(d);
						phase   = PH_EDIG;
					end else begin
						flag_error();
					end
				end
			end
			PH_EFIRST: begin
				if (is_dig) begin
					rng_end = 64'(d);
					phase   = PH_EDIG;
				end else begin
					flag_error();
				end
			end
			PH_EDIG: begin
				if (is_dig) begin
					if (digit_fits(rng_end, d))
						rng_end = rng_end * 10 + 64'(d);
					else
						flag_error();
				end else if (c == CH_SPACE) begin
					phase = PH_ESP;
				end else if (ends_spec) begin
					clamp_and_close(c);
				end else begin
					flag_error();
				end
			end
			PH_ESP: begin
				if (c != CH_SPACE) begin
					if (ends_spec)
						clamp_and_close(c);
					else
						flag_error();
				end
			end
			default: begin
				flag_error();
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsize = '0;
			clear_header();
			due_beats.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_beats.size() == 0) begin
					report_mismatch("result beat with nothing expected", m_tdata[63:0], 64'd0);
				end else begin
					want = due_beats.pop_front();
					check_field("kind", m_tuser, want.kind);
					check_field("offset", m_tdata[OUT_W-1:0], want.offset);
					check_field("length", m_tdata[2*OUT_W-1:OUT_W], want.length);
					check_field("status", m_tdata[2*OUT_W+1:2*OUT_W], want.status);
					check_field("range_count", m_tdata[2*OUT_W+9:2*OUT_W+2], want.range_count);
					check_field("total_bytes", m_tdata[3*OUT_W+9:2*OUT_W+10], want.total_bytes);
					check_field("last", m_tlast, want.last);
				end
			end
			if (file_size_wr_en)
				fsize = 64'(file_size);
			if (s_tvalid && s_tready) begin
				if (!s_tlast) begin
					if (!halted)
						parse_char(s_tdata);
				end else begin
					if (!halted)
						parse_char(CH_NUL);
					if (spec_error)
						expect_beat(1'b1, 64'd0, 64'd0, ST_UNSAT, byte_total);
					else if (range_cnt != 0)
						expect_beat(1'b1, 64'd0, 64'd0, ST_PARTIAL, byte_total);
					else
						expect_beat(1'b1, 64'd0, fsize, ST_WHOLE, fsize);
					clear_header();
				end
			end
		end
		mismatches  <= err_count;
		outstanding <= due_beats.size();
	end

endmodule

/* test/http_byte_range_parser_tb.sv */
// Testbench top for the HTTP byte-range parser: clock, reset, header stimulus and verdict.
module http_byte_range_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hbrp_pkg::*;

	localparam int          ITEM_TARGET = 1650;
	localparam int          CYCLE_LIMIT = 500000;
	localparam int          HOLD_CYCLES = 300;
	localparam logic [63:0] VMAX48      = 64'h0000_FFFF_FFFF_FFFF;

	logic               clk             = 1'b0;
	logic               arst_n          = 1'b0;
	logic               file_size_wr_en = 1'b0;
	logic [OUT_W-1:0]   file_size       = '0;
	logic               s_tvalid        = 1'b0;
	logic               s_tready;
	logic [SDATA_W-1:0] s_tdata         = '0;
	logic               s_tlast         = 1'b0;
	logic               m_tvalid;
	logic               m_tready        = 1'b0;
	logic [MDATA_W-1:0] m_tdata;
	logic               m_tuser;
	logic               m_tlast;

	int          mismatches;
	int          outstanding;
	int          cycles      = 0;
	int          items_sent  = 0;
	int          burst_left  = 0;
	bit          gaps_off    = 1'b0;
	logic        hold_req    = 1'b0;
	logic        hold_armed  = 1'b0;
	int          hold_left   = 0;
	int          rx_mode     = 0;
	int          mode_left   = 0;
	logic [63:0] fs_now      = '0;
	logic [7:0]  hdr[$];

	http_byte_range_parser i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.file_size_wr_en (file_size_wr_en),
		.file_size       (file_size),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.m_tlast         (m_tlast)
	);

	http_byte_range_parser_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.file_size_wr_en (file_size_wr_en),
		.file_size       (file_size),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.m_tlast         (m_tlast),
		.mismatches      (mismatches),
		.outstanding     (outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side: stall mode changes now and then; a hold request gives one long stall
	always @(posedge clk) begin
		if (mode_left == 0) begin
			rx_mode   <= $urandom_range(0, 3);
			mode_left <= $urandom_range(64, 512);
		end else begin
			mode_left <= mode_left - 1;
		end
		if (!hold_req)
			hold_armed <= 1'b0;
		if (hold_req && !hold_armed) begin
			hold_armed <= 1'b1;
			hold_left  <= HOLD_CYCLES;
			m_tready   <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			case (rx_mode)
				0:       m_tready <= 1'b1;
				1:       m_tready <= $urandom_range(0, 3) != 0;
				2:       m_tready <= $urandom_range(0, 3) == 0;
				default: m_tready <= (cycles % 5) < 2;
			endcase
		end
	end

	task automatic send_item(input logic [7:0] c, input logic at_end);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if (!gaps_off && $urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= at_end;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic send_header();
		foreach (hdr[i])
			send_item(hdr[i], 1'b0);
		send_item(8'($urandom), 1'b1);
		hdr.delete();
	endtask

	task automatic drain();
		s_tvalid   <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_file_size(input logic [63:0] v);
		drain();
		repeat (4) @(posedge clk);
		file_size_wr_en <= 1'b1;
		file_size       <= v[OUT_W-1:0];
		fs_now          = 64'(v[OUT_W-1:0]);
		@(posedge clk);
		file_size_wr_en <= 1'b0;
	endtask

	task automatic add_byte(input logic [7:0] b);
		hdr.insert(hdr.size(), b);
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task automatic put_spaces();
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) add_byte(CH_SPACE);
	endtask

	task automatic put_number(input logic [63:0] v);
		logic [7:0] digs[$];
		if ($urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 3)) add_byte(CH_ZERO);
		do begin
			digs.push_front(CH_ZERO + 8'(v % 10));
			v = v / 10;
		end while (v != 0);
		foreach (digs[i])
			add_byte(digs[i]);
	endtask

	function automatic logic [63:0] pick_value();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 15))
			0, 1, 2: return 64'($urandom_range(0, 9));
			3, 4:    return fs_now >= 3 ? fs_now - 64'($urandom_range(0, 3)) : 64'd0;
			5, 6:    return fs_now + 64'($urandom_range(0, 3));
			7, 8, 9: return r % (fs_now + 64'd1);
			10:      return r & VMAX48;
			11:      return VMAX48;
			12:      return $urandom_range(0, 1) ? VMAX48 + 64'd1 : r;
			default: return 64'($urandom_range(0, 1000));
		endcase
	endfunction

	// mostly well-formed spec lists with random content, some broken or noise headers
	task automatic random_header();
		int sel;
		int n_specs;
		int form;
		sel = $urandom_range(0, 19);
		if (sel == 1) begin
			repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
		end else if (sel != 0) begin
			put_text("bytes=");
			for (int i = 0; i < 5; i++)
				if ($urandom_range(0, 1))
					hdr[i] = hdr[i] - 8'h20;
			if (sel == 2)
				hdr[$urandom_range(0, 5)] = 8'($urandom);
			if (sel == 3)
				repeat ($urandom_range(1, 5)) void'(hdr.pop_back());
			n_specs = $urandom_range(0, 4);
			for (int k = 0; k < n_specs; k++) begin
				if (k != 0)
					add_byte(CH_COMMA);
				put_spaces();
				form = $urandom_range(0, 2);
				if (form == 2) begin
					add_byte(CH_DASH);
					if ($urandom_range(0, 15) == 0)
						add_byte(CH_SPACE);
					put_number(pick_value());
				end else begin
					put_number(pick_value());
					put_spaces();
					add_byte(CH_DASH);
					put_spaces();
					if (form == 0)
						put_number(pick_value());
				end
				put_spaces();
				if ($urandom_range(0, 24) == 0)
					add_byte(8'($urandom));
			end
			case ($urandom_range(0, 15))
				0: add_byte(CH_COMMA);
				1: begin
					add_byte(CH_COMMA);
					add_byte(CH_CR);
				end
				2: begin
					add_byte(CH_CR);
					add_byte(8'($urandom));
				end
				3: begin
					add_byte(CH_NUL);
					repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
				end
				default: ;
			endcase
		end
		send_header();
	endtask

	initial begin
		logic [63:0] fs_pick;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty header at reset size, missing prefix, mixed specs, open range
		send_header();
		write_file_size(64'd100);
		put_text("x");
		send_header();
		put_text("BYTES=1-2,-3");
		send_header();
		put_text("bytes=5-");
		send_header();

		for (int ph = 0; items_sent < ITEM_TARGET; ph++) begin
			fs_pick = {$urandom, $urandom};
			case (ph % 6)
				0:       fs_pick = 64'd0;
				1:       fs_pick = 64'd1;
				2:       fs_pick = 64'($urandom_range(2, 2000));
				3:       fs_pick = fs_pick & VMAX48;
				4:       fs_pick = VMAX48;
				default: fs_pick = 64'($urandom_range(0, 50));
			endcase
			write_file_size(fs_pick);
			if (ph == 1) begin
				// enough one-byte suffix ranges to saturate range_count
				put_text("bytes=");
				repeat (258) put_text("-1,");
				send_header();
			end
			if (ph == 2) begin
				hold_req <= 1'b1;
				gaps_off = 1'b1;
				repeat (10) random_header();
				hold_req <= 1'b0;
				gaps_off = 1'b0;
				drain();
			end
			repeat (12) random_header();
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* files.f */
hdl/hbrp_pkg.sv
hdl/http_byte_range_parser.sv
test/http_byte_range_parser_checker.sv
test/http_byte_range_parser_tb.sv
